// ===== src/fifo_queue_with_remove_by_id_assert.svh =====
// Assertion macros used by the queue sequencer.
`ifndef FIFO_QUEUE_WITH_REMOVE_BY_ID_ASSERT_SVH
`define FIFO_QUEUE_WITH_REMOVE_BY_ID_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FQR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FQR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fqr_pkg.sv =====
// Package: sizes, codes and bundle types of the keyed-remove queue.
`default_nettype none
package fqr_pkg;

  localparam int DEPTH  = 16;
  localparam int ID_W   = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SLOT_W = ID_W + DATA_W;

  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_FIND = 2'd2
  } fqr_req_type_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } fqr_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_RESP
  } fqr_state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ID_W-1:0]   item_id;
    logic [DATA_W-1:0] item_data;
  } fqr_req_t;

  typedef struct packed {
    fqr_status_t       status;
    logic [ID_W-1:0]   out_id;
    logic [DATA_W-1:0] out_data;
    logic [CNT_W-1:0]  entry_count;
    logic              is_empty;
  } fqr_res_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [SLOT_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } fqr_ram_req_t;

  // Map a queue position (0 = head) to its circular slot address.
  function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(head) + (CNT_W + 1)'(pos);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/fqr_if.sv =====
// Request and result channel interfaces of the keyed-remove queue.
`default_nettype none
interface fqr_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [fqr_pkg::ID_W-1:0]   item_id;
  logic [fqr_pkg::DATA_W-1:0] item_data;

  modport source (output valid, output req_type, output item_id, output item_data,
                  input ready);
  modport sink (input valid, input req_type, input item_id, input item_data,
                output ready);
endinterface

interface fqr_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [fqr_pkg::ID_W-1:0]   out_id;
  logic [fqr_pkg::DATA_W-1:0] out_data;
  logic [fqr_pkg::CNT_W-1:0]  entry_count;
  logic                      is_empty;

  modport source (output valid, output status, output out_id, output out_data,
                  output entry_count, output is_empty, input ready);
  modport sink (input valid, input status, input out_id, input out_data,
                input entry_count, input is_empty, output ready);
endinterface
`default_nettype wire

// ===== src/fifo_queue_with_remove_by_id.sv =====
// Top level: request and result channels, result register, slot store and sequencer.
// Usage:
//   in_chan carries one request (enqueue, dequeue head, or find-and-remove by id)
//   with valid/ready; out_chan returns exactly one result per request, in order,
//   with status, the removed entry (zero when none), entry count and empty flag.
//   One request is in work at a time; in_chan.ready is high while the sequencer idles.
//   The work per request is set by the slot store's registered read and the shared
//   id comparator: enqueue, a rejected request or an unused code goes straight to
//   the result state; dequeue reads the head entry first; find-and-remove reads and
//   compares each entry up to the match, then reads and writes each later entry to
//   move it down, so it walks all held entries whether or not an entry matches.
//   The result state follows, which hands the result to the result register that
//   drives out_chan; the sequencer then returns to idle and takes the next request.
//   The result register parts the two sides: a new request is taken while a result
//   waits; when the receiver stalls, the next finished result holds in the sequencer.
//   Reset (rst_n low, synchronous) empties the queue at once; slot contents are not
//   cleared and need no clearing pass.
`default_nettype none
module fifo_queue_with_remove_by_id (
  input  wire logic clk,
  input  wire logic rst_n,
  fqr_in_if.sink    in_chan,
  fqr_out_if.source out_chan
);
  import fqr_pkg::*;

  fqr_req_t          req;
  fqr_res_t          res;
  fqr_res_t          out_res_r;
  fqr_ram_req_t      ram_req;
  logic [SLOT_W-1:0] ram_rdata;
  logic              seq_ready;
  logic              start;
  logic              res_valid;
  logic              res_load;
  logic              out_valid_r, out_valid_nxt;

  assign req.req_type  = in_chan.req_type;
  assign req.item_id   = in_chan.item_id;
  assign req.item_data = in_chan.item_data;
  assign in_chan.ready = seq_ready;
  assign start         = in_chan.valid && seq_ready;

  // Load the result register when it is empty or being drained.
  assign res_load = res_valid && (!out_valid_r || out_chan.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_res_r.status;
  assign out_chan.out_id      = out_res_r.out_id;
  assign out_chan.out_data    = out_res_r.out_data;
  assign out_chan.entry_count = out_res_r.entry_count;
  assign out_chan.is_empty    = out_res_r.is_empty;

  fqr_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  fqr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .in_ready  (seq_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_load),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// ===== src/fqr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fqr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/fqr_seq.sv =====
// Sequencer: walks the slot store one entry at a time with a shared id comparator.
`default_nettype none
`include "fifo_queue_with_remove_by_id_assert.svh"
module fqr_seq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire fqr_pkg::fqr_req_t             req,
  output logic                               in_ready,
  output logic                               res_valid,
  output fqr_pkg::fqr_res_t                  res,
  input  wire logic                          res_taken,
  output fqr_pkg::fqr_ram_req_t              ram_req,
  input  wire logic [fqr_pkg::SLOT_W-1:0]    ram_rdata
);
  import fqr_pkg::*;

  fqr_state_t        state_r,  state_nxt;
  logic [IDX_W-1:0]  head_r,   head_nxt;
  logic [CNT_W-1:0]  count_r,  count_nxt;
  logic [CNT_W-1:0]  pos_r,    pos_nxt;
  logic [ID_W-1:0]   key_r,    key_nxt;
  fqr_status_t       status_r, status_nxt;
  logic [ID_W-1:0]   rid_r,    rid_nxt;
  logic [DATA_W-1:0] rdat_r,   rdat_nxt;

  logic [CNT_W-1:0]  pos_inc;
  logic              pos_last;
  logic              id_match;

  assign pos_inc  = pos_r + 1'b1;
  assign pos_last = (pos_inc == count_r);
  assign id_match = (ram_rdata[DATA_W +: ID_W] == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    rid_r    <= rid_nxt;
    rdat_r   <= rdat_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    key_nxt    = key_r;
    status_nxt = status_r;
    rid_nxt    = rid_r;
    rdat_nxt   = rdat_r;
    ram_req    = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt    = req.item_id;
          status_nxt = STAT_OK;
          rid_nxt    = '0;
          rdat_nxt   = '0;
          pos_nxt    = '0;
          state_nxt  = ST_RESP;
          case (req.req_type)
            REQ_ENQ: begin
              if (count_r == CNT_W'(DEPTH)) begin
                status_nxt = STAT_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = slot_addr(head_r, count_r);
                ram_req.wdata = {req.item_id, req.item_data};
                count_nxt     = count_r + 1'b1;
              end
            end
            REQ_DEQ: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = head_r;
                state_nxt     = ST_DEQ;
              end
            end
            REQ_FIND: begin
              if (count_r == '0) begin
                status_nxt = STAT_NOTFOUND;
              end else begin
                state_nxt = ST_SCAN_RD;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_DEQ: begin
        rid_nxt   = ram_rdata[DATA_W +: ID_W];
        rdat_nxt  = ram_rdata[DATA_W-1:0];
        head_nxt  = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
        count_nxt = count_r - 1'b1;
        state_nxt = ST_RESP;
      end

      ST_SCAN_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = slot_addr(head_r, pos_r);
        state_nxt     = ST_SCAN_CMP;
      end

      ST_SCAN_CMP: begin
        pos_nxt = pos_inc;
        if (id_match) begin
          rid_nxt  = ram_rdata[DATA_W +: ID_W];
          rdat_nxt = ram_rdata[DATA_W-1:0];
          if (pos_last) begin
            count_nxt = count_r - 1'b1;
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_SH_RD;
          end
        end else if (pos_last) begin
          status_nxt = STAT_NOTFOUND;
          state_nxt  = ST_RESP;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end

      // Close the gap: move each later entry down one position.
      ST_SH_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = slot_addr(head_r, pos_r);
        state_nxt     = ST_SH_WR;
      end

      ST_SH_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = slot_addr(head_r, pos_r - 1'b1);
        ram_req.wdata = ram_rdata;
        pos_nxt       = pos_inc;
        if (pos_last) begin
          count_nxt = count_r - 1'b1;
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_SH_RD;
        end
      end

      ST_RESP: begin
        if (res_taken) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign res_valid       = (state_r == ST_RESP);
  assign res.status      = status_r;
  assign res.out_id      = rid_r;
  assign res.out_data    = rdat_r;
  assign res.entry_count = count_r;
  assign res.is_empty    = (count_r == '0);

  `FQR_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "entry count above depth")
  `FQR_ASSERT_NOW(a_scan_in_range, state_r == ST_SCAN_RD || state_r == ST_SH_RD, pos_r < count_r, "walk position past tail")
  `FQR_ASSERT_NEXT(a_enq_grows, state_r == ST_IDLE && start && req.req_type == REQ_ENQ && count_r != CNT_W'(DEPTH), count_r == $past(count_r) + 1'b1, "enqueue did not add an entry")
  `FQR_ASSERT_NEXT(a_deq_shrinks, state_r == ST_DEQ, count_r == $past(count_r) - 1'b1, "dequeue did not drop an entry")

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for the keyed-remove queue: random traffic, in-bench queue model, result checks.
`timescale 1ns / 1ps
module testbench;
  import fqr_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int ITEM_TARGET   = 950;
  localparam int DRAIN_CYCLES  = 4 * DEPTH + 16;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef enum int {RX_FREE, RX_COIN, RX_PATTERN, RX_CHOKE} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic req_accepted = 1'b0;

  fqr_in_if  in_chan ();
  fqr_out_if out_chan ();

  fifo_queue_with_remove_by_id i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  fqr_req_t pending_reqs[$];
  fqr_res_t expected_results[$];
  entry_t   held_entries[$];

  int fail_count = 0;
  int result_index = 0;
  int burst_left = 0;
  int gap_left = 0;
  int mode_left = 0;
  int pat_idx = 0;
  logic [31:0] stall_pattern = '0;
  rx_mode_t rx_mode = RX_FREE;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    in_chan.valid     = 1'b0;
    in_chan.req_type  = REQ_ENQ;
    in_chan.item_id   = '0;
    in_chan.item_data = '0;
    out_chan.ready    = 1'b0;
  end

  // Apply one request to the queue model and return the result it yields.
  function automatic fqr_res_t queue_apply(input fqr_req_t r);
    fqr_res_t res;
    int hit;
    res = '0;
    res.status = STAT_OK;
    hit = -1;
    case (r.req_type)
      REQ_ENQ: begin
        if (held_entries.size() >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          held_entries.push_back({r.item_id, r.item_data});
        end
      end
      REQ_DEQ: begin
        if (held_entries.size() == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.out_id   = held_entries[0].id;
          res.out_data = held_entries[0].data;
          void'(held_entries.pop_front());
        end
      end
      REQ_FIND: begin
        for (int i = 0; i < held_entries.size(); i++) begin
          if (hit < 0 && held_entries[i].id == r.item_id) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          res.status = STAT_NOTFOUND;
        end else begin
          res.out_id   = held_entries[hit].id;
          res.out_data = held_entries[hit].data;
          held_entries.delete(hit);
        end
      end
      default: ;
    endcase
    res.entry_count = CNT_W'(held_entries.size());
    res.is_empty    = (held_entries.size() == 0);
    return res;
  endfunction

  task automatic add_req(input logic [1:0] kind, input logic [ID_W-1:0] id,
                         input logic [DATA_W-1:0] data);
    fqr_req_t r;
    r.req_type  = kind;
    r.item_id   = id;
    r.item_data = data;
    pending_reqs.push_back(r);
  endtask

  // Mostly a small key pool so finds hit and duplicates occur; sometimes any key.
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 3) == 0) begin
      return ID_W'($urandom);
    end
    return ID_W'($urandom_range(0, 7));
  endfunction

  // Request side: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    fqr_req_t r;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || req_accepted) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_chan.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        r = pending_reqs.pop_front();
        in_chan.req_type  <= r.req_type;
        in_chan.item_id   <= r.item_id;
        in_chan.item_data <= r.item_data;
        in_chan.valid     <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Record accepted requests and predict their results.
  always @(posedge clk) begin
    fqr_req_t taken;
    req_accepted <= rst_n && in_chan.valid && in_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      taken.req_type  = in_chan.req_type;
      taken.item_id   = in_chan.item_id;
      taken.item_data = in_chan.item_data;
      expected_results.push_back(queue_apply(taken));
    end
  end

  // Result side: stall in windows of varying character.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode       = rx_mode_t'($urandom_range(0, 3));
        mode_left     = $urandom_range(20, 80);
        stall_pattern = $urandom;
      end else begin
        mode_left = mode_left - 1;
      end
      pat_idx = pat_idx + 1;
      case (rx_mode)
        RX_FREE:    out_chan.ready <= 1'b1;
        RX_COIN:    out_chan.ready <= 1'($urandom_range(0, 1));
        RX_PATTERN: out_chan.ready <= stall_pattern[pat_idx % 32];
        default:    out_chan.ready <= (pat_idx % 16) >= 12;
      endcase
    end
  end

  // Compare each result with the oldest prediction.
  always @(posedge clk) begin
    fqr_res_t seen;
    fqr_res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen.status      = fqr_status_t'(out_chan.status);
      seen.out_id      = out_chan.out_id;
      seen.out_data    = out_chan.out_data;
      seen.entry_count = out_chan.entry_count;
      seen.is_empty    = out_chan.is_empty;
      if (expected_results.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= REPORT_LIMIT) begin
          $display("result %0d arrived with no request outstanding: status=%0d id=%h",
                   result_index, seen.status, seen.out_id);
        end
      end else begin
        want = expected_results.pop_front();
        if (seen !== want) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_LIMIT) begin
            $display("result %0d mismatch: expected status=%0d id=%h data=%h count=%0d empty=%0b",
                     result_index, want.status, want.out_id, want.out_data,
                     want.entry_count, want.is_empty);
            $display("  got                  status=%0d id=%h data=%h count=%0d empty=%0b",
                     seen.status, seen.out_id, seen.out_data, seen.entry_count,
                     seen.is_empty);
          end
        end
      end
      result_index = result_index + 1;
    end
  end

  initial begin
    int enq_pct;
    int roll;
    logic [ID_W-1:0] id;

    // Directed: empty-queue cases, fill to capacity, overflow, keyed removes.
    add_req(REQ_DEQ, '0, '0);
    add_req(REQ_FIND, 16'h1234, '0);
    add_req(REQ_UNUSED, 16'h5555, 32'hDEADBEEF);
    add_req(REQ_ENQ, 16'h0000, 32'h0000_0000);
    add_req(REQ_ENQ, 16'hFFFF, 32'hFFFF_FFFF);
    for (int i = 2; i < DEPTH - 1; i++) begin
      add_req(REQ_ENQ, ID_W'(i % 4 + 1), $urandom);
    end
    add_req(REQ_ENQ, 16'hABCD, $urandom);
    add_req(REQ_ENQ, 16'h7777, $urandom);
    add_req(REQ_FIND, 16'h4321, '0);
    add_req(REQ_FIND, 16'h0003, '0);
    add_req(REQ_FIND, 16'hABCD, '0);
    add_req(REQ_FIND, 16'h0000, '0);
    add_req(REQ_FIND, 16'hFFFF, '0);
    add_req(REQ_DEQ, '0, '0);
    add_req(REQ_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);

    // Random: phases that lean toward filling, draining or balance.
    enq_pct = 50;
    while (pending_reqs.size() < ITEM_TARGET) begin
      if (pending_reqs.size() % 25 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 15;
          1:       enq_pct = 50;
          default: enq_pct = 85;
        endcase
      end
      id = pick_id();
      if ($urandom_range(0, 99) < 3) begin
        add_req(REQ_UNUSED, id, $urandom);
      end else if ($urandom_range(0, 99) < enq_pct) begin
        add_req(REQ_ENQ, id, $urandom);
      end else begin
        roll = $urandom_range(0, 1);
        add_req(roll == 0 ? REQ_DEQ : REQ_FIND, id, $urandom);
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_chan.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/fqr_pkg.sv
src/fqr_if.sv
src/fqr_ram.sv
src/fqr_seq.sv
src/fifo_queue_with_remove_by_id.sv
bench/testbench.sv
